@@ rtl/ssc_pkg.sv @@
// Shared types and constants for the sphere pair contact pipeline.
// No dependencies; used by every module under rtl.
package ssc_pkg;

  localparam int unsigned CoordW  = 24;
  localparam int unsigned RadW    = 23;
  localparam int unsigned NormW   = 16;
  localparam int unsigned SqW     = 52;
  localparam int unsigned DistW   = 26;
  localparam int unsigned QuoW    = 15;
  localparam int unsigned RemW    = 42;
  localparam int unsigned ThrW    = 52;
  localparam int unsigned AddrW   = 4;
  localparam int unsigned DataW   = 64;

  // Register index of the coincidence threshold (byte address 8*index).
  localparam logic [0:0] RegThreshold = 1'b0;
  localparam logic [ThrW-1:0] ThresholdReset = 52'd1;

  localparam logic [QuoW-1:0] OneQ14 = 15'd16384;

  typedef struct packed {
    logic signed [23:0] first_x;
    logic signed [23:0] first_y;
    logic signed [23:0] first_z;
    logic signed [23:0] second_x;
    logic signed [23:0] second_y;
    logic signed [23:0] second_z;
    logic        [22:0] first_radius;
    logic        [22:0] second_radius;
  } in_word_t;

  typedef struct packed {
    logic               coincident;
    logic        [23:0] depth;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic signed [23:0] contact_x;
    logic signed [23:0] contact_y;
    logic signed [23:0] contact_z;
  } out_word_t;

  // Per-item context that rides along the pipeline.
  typedef struct packed {
    logic [2:0][23:0] c1;
    logic [2:0][23:0] dmag;
    logic [2:0]       dneg;
    logic [22:0]      r1;
    logic [22:0]      rmax;
    logic [23:0]      rsum;
    logic             coinc;
  } ctx_t;

endpackage

@@ rtl/ssc_front.sv @@
// Front stages: center difference, squares, squared-distance sum, separation
// and coincidence tests. Depends on ssc_pkg.
module ssc_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  ssc_pkg::in_word_t         word_i,
  input  logic [ssc_pkg::ThrW-1:0]  thr_i,
  output logic                      valid_o,
  output ssc_pkg::ctx_t             ctx_o,
  output logic [ssc_pkg::SqW-1:0]   sq_o
);

  logic [2:0][23:0] fc, sc, mag_d;
  logic [2:0]       neg_d;
  logic [2:0][24:0] diff;

  logic v1_q, v2_q, v3_q, v4_q;
  ssc_pkg::ctx_t ctx1_q, ctx2_q, ctx3_q, ctx4_q;
  ssc_pkg::ctx_t ctx3_c;
  logic [2:0][47:0] sql_q;
  logic [ssc_pkg::SqW-1:0] sq3_q, sq4_q;
  logic [47:0] rsq3_q;

  // Lane split and signed difference second - first
  always_comb begin
    fc[0] = word_i.first_x;  fc[1] = word_i.first_y;  fc[2] = word_i.first_z;
    sc[0] = word_i.second_x; sc[1] = word_i.second_y; sc[2] = word_i.second_z;
    for (int l = 0; l < 3; l++) begin
      diff[l]  = {sc[l][23], sc[l]} - {fc[l][23], fc[l]};
      neg_d[l] = diff[l][24];
      mag_d[l] = neg_d[l] ? 24'(-diff[l]) : diff[l][23:0];
    end
  end

  // Coincidence flag joins the context
  always_comb begin
    ctx3_c       = ctx3_q;
    ctx3_c.coinc = sq3_q < thr_i;
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q && !({4'b0, rsq3_q} < sq3_q);
    end
  end

  // Data stages
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctx1_q.c1    <= fc;
      ctx1_q.dmag  <= mag_d;
      ctx1_q.dneg  <= neg_d;
      ctx1_q.r1    <= word_i.first_radius;
      ctx1_q.rmax  <= (word_i.first_radius > word_i.second_radius) ?
                      word_i.first_radius : word_i.second_radius;
      ctx1_q.rsum  <= {1'b0, word_i.first_radius} + {1'b0, word_i.second_radius};
      ctx1_q.coinc <= 1'b0;

      for (int l = 0; l < 3; l++) sql_q[l] <= ctx1_q.dmag[l] * ctx1_q.dmag[l];
      ctx2_q <= ctx1_q;

      sq3_q  <= {4'b0, sql_q[0]} + {4'b0, sql_q[1]} + {4'b0, sql_q[2]};
      rsq3_q <= ctx2_q.rsum * ctx2_q.rsum;
      ctx3_q <= ctx2_q;

      sq4_q  <= sq3_q;
      ctx4_q <= ctx3_c;
    end
  end

  assign valid_o = v4_q;
  assign ctx_o   = ctx4_q;
  assign sq_o    = sq4_q;

endmodule

@@ rtl/ssc_sqrt.sv @@
// Pipelined integer square root, one result bit per stage (26 stages).
// Depends on ssc_pkg.
module ssc_sqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  ssc_pkg::ctx_t              ctx_i,
  input  logic [ssc_pkg::SqW-1:0]    sq_i,
  output logic                       valid_o,
  output ssc_pkg::ctx_t              ctx_o,
  output logic [ssc_pkg::DistW-1:0]  dist_o
);

  localparam int unsigned N = ssc_pkg::DistW;

  logic [N-1:0]                 v_q;
  ssc_pkg::ctx_t                ctx_q  [N];
  logic [ssc_pkg::SqW-1:0]      sq_q   [N];
  logic [26:0]                  rem_q  [N];
  logic [N-1:0]                 root_q [N];

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic          vin;
    ssc_pkg::ctx_t cin;
    logic [ssc_pkg::SqW-1:0] sin;
    logic [26:0]   rin;
    logic [N-1:0]  oin;
    logic [28:0]   r2, trial;

    if (i == 0) begin : g_first
      assign vin = valid_i; assign cin = ctx_i; assign sin = sq_i;
      assign rin = '0;      assign oin = '0;
    end else begin : g_next
      assign vin = v_q[i-1]; assign cin = ctx_q[i-1]; assign sin = sq_q[i-1];
      assign rin = rem_q[i-1]; assign oin = root_q[i-1];
    end

    // Bring down the next two radicand bits and try root*4+1
    assign r2    = {rin, sin[ssc_pkg::SqW-1-2*i -: 2]};
    assign trial = {1'b0, oin, 2'b01};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (en_i) begin
        v_q[i] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ctx_q[i] <= cin;
        sq_q[i]  <= sin;
        if (r2 >= trial) begin
          rem_q[i]  <= 27'(r2 - trial);
          root_q[i] <= {oin[N-2:0], 1'b1};
        end else begin
          rem_q[i]  <= r2[26:0];
          root_q[i] <= {oin[N-2:0], 1'b0};
        end
      end
    end
  end

  assign valid_o = v_q[N-1];
  assign ctx_o   = ctx_q[N-1];
  assign dist_o  = root_q[N-1];

endmodule

@@ rtl/ssc_div.sv @@
// Pipelined restoring divider for the three normal components, one quotient
// bit per stage: q = (|d|*32768 + D) / (2*D). Depends on ssc_pkg.
module ssc_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  ssc_pkg::ctx_t                     ctx_i,
  input  logic [ssc_pkg::DistW-1:0]         dist_i,
  output logic                              valid_o,
  output ssc_pkg::ctx_t                     ctx_o,
  output logic [ssc_pkg::DistW-1:0]         dist_o,
  output logic [2:0][ssc_pkg::QuoW-1:0]     quo_o
);

  localparam int unsigned N = ssc_pkg::QuoW;
  localparam int unsigned W = ssc_pkg::RemW;

  logic [N-1:0]                   v_q;
  ssc_pkg::ctx_t                  ctx_q  [N];
  logic [ssc_pkg::DistW-1:0]      dist_q [N];
  logic [2:0][W-1:0]              rem_q  [N];
  logic [2:0][N-1:0]              quo_q  [N];

  for (genvar j = 0; j < N; j++) begin : g_stage
    localparam int unsigned K = N - 1 - j;
    logic                       vin;
    ssc_pkg::ctx_t              cin;
    logic [ssc_pkg::DistW-1:0]  din;
    logic [2:0][W-1:0]          rin;
    logic [2:0][N-1:0]          qin;
    logic [W-1:0]               den_sh;

    if (j == 0) begin : g_first
      assign vin = valid_i; assign cin = ctx_i; assign din = dist_i;
      assign qin = '0;
      always_comb begin
        for (int l = 0; l < 3; l++)
          rin[l] = {3'b0, ctx_i.dmag[l], 15'b0} + {16'b0, dist_i};
      end
    end else begin : g_next
      assign vin = v_q[j-1]; assign cin = ctx_q[j-1]; assign din = dist_q[j-1];
      assign rin = rem_q[j-1]; assign qin = quo_q[j-1];
    end

    // Divisor 2*D aligned to this quotient bit
    assign den_sh = {15'b0, din, 1'b0} << K;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else if (en_i) begin
        v_q[j] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ctx_q[j]  <= cin;
        dist_q[j] <= din;
        for (int l = 0; l < 3; l++) begin
          if (rin[l] >= den_sh) begin
            rem_q[j][l] <= rin[l] - den_sh;
            quo_q[j][l] <= qin[l] | ({{(N-1){1'b0}}, 1'b1} << K);
          end else begin
            rem_q[j][l] <= rin[l];
            quo_q[j][l] <= qin[l];
          end
        end
      end
    end
  end

  assign valid_o = v_q[N-1];
  assign ctx_o   = ctx_q[N-1];
  assign dist_o  = dist_q[N-1];
  assign quo_o   = quo_q[N-1];

endmodule

@@ rtl/ssc_back.sv @@
// Back stages: normal sign and clamp, contact offset multiply, rounding,
// saturation, coincident fallback and the output register. Depends on ssc_pkg.
module ssc_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  ssc_pkg::ctx_t                  ctx_i,
  input  logic [ssc_pkg::DistW-1:0]      dist_i,
  input  logic [2:0][ssc_pkg::QuoW-1:0]  quo_i,
  output logic                           valid_o,
  output ssc_pkg::out_word_t             word_o
);

  logic [2:0][ssc_pkg::QuoW-1:0] qc;
  logic                          b1_v_q, b2_v_q;
  ssc_pkg::ctx_t                 b1_ctx_q;
  logic [ssc_pkg::DistW-1:0]     b1_dist_q;
  logic [2:0][ssc_pkg::QuoW-1:0] b1_q_q;
  logic [2:0][37:0]              b1_prod_q;
  ssc_pkg::out_word_t            word_d, word_q;

  // Clamp to one; zero distance gives a zero normal
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      if (dist_i == '0) qc[l] = '0;
      else if (quo_i[l] > ssc_pkg::OneQ14) qc[l] = ssc_pkg::OneQ14;
      else qc[l] = quo_i[l];
    end
  end

  // Result assembly
  always_comb begin
    logic [2:0][15:0] n;
    logic [2:0][38:0] rnd;
    logic [2:0][26:0] p;
    logic [2:0][23:0] ps;
    for (int l = 0; l < 3; l++) begin
      n[l]   = b1_ctx_q.dneg[l] ? 16'(-{1'b0, b1_q_q[l]}) : {1'b0, b1_q_q[l]};
      rnd[l] = {1'b0, b1_prod_q[l]} + 39'd8192;
      if (b1_ctx_q.dneg[l])
        p[l] = {{3{b1_ctx_q.c1[l][23]}}, b1_ctx_q.c1[l]} - {2'b0, rnd[l][38:14]};
      else
        p[l] = {{3{b1_ctx_q.c1[l][23]}}, b1_ctx_q.c1[l]} + {2'b0, rnd[l][38:14]};
      if (!p[l][26] && p[l][25:23] != 3'b000) ps[l] = 24'h7FFFFF;
      else if (p[l][26] && p[l][25:23] != 3'b111) ps[l] = 24'h800000;
      else ps[l] = p[l][23:0];
    end
    word_d.coincident = b1_ctx_q.coinc;
    if (b1_ctx_q.coinc) begin
      word_d.depth     = {1'b0, b1_ctx_q.rmax};
      word_d.normal_x  = '0;
      word_d.normal_y  = 16'(ssc_pkg::OneQ14);
      word_d.normal_z  = '0;
      word_d.contact_x = b1_ctx_q.c1[0];
      word_d.contact_y = b1_ctx_q.c1[1];
      word_d.contact_z = b1_ctx_q.c1[2];
    end else begin
      word_d.depth     = b1_ctx_q.rsum - b1_dist_q[23:0];
      word_d.normal_x  = n[0];
      word_d.normal_y  = n[1];
      word_d.normal_z  = n[2];
      word_d.contact_x = ps[0];
      word_d.contact_y = ps[1];
      word_d.contact_z = ps[2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_v_q <= 1'b0;
      b2_v_q <= 1'b0;
    end else if (en_i) begin
      b1_v_q <= valid_i;
      b2_v_q <= b1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b1_ctx_q  <= ctx_i;
      b1_dist_q <= dist_i;
      b1_q_q    <= qc;
      for (int l = 0; l < 3; l++) b1_prod_q[l] <= qc[l] * ctx_i.r1;
      word_q    <= word_d;
    end
  end

  assign valid_o = b2_v_q;
  assign word_o  = word_q;

endmodule

@@ rtl/sphere_sphere_contact.sv @@
// Sphere pair contact generator: top level, config register and stall control.
// Depends on ssc_pkg, ssc_front, ssc_sqrt, ssc_div and ssc_back.
//
// Usage: sphere pairs enter on the in channel (in_valid_i / in_ready_o /
// in_word_i), one word per cycle. A pair that overlaps or touches produces one
// word on the out channel (out_valid_o / out_ready_i / out_word_o); a
// separated pair produces nothing. Words leave in input order.
// From acceptance to out_valid_o a pair passes 4 front stages, 26 square-root
// stages (one root bit each), 15 divider stages (one normal bit each) and 2
// back stages including the output register.
// Throughput is one pair per cycle while the receiver takes results.
// When out_valid_o is high and out_ready_i low, the whole pipeline holds and
// in_ready_o drops; nothing is lost or repeated.
// Reset clears all valid bits and sets coincide_threshold to 1. The threshold
// is a 64-bit APB register at byte address 0 (low 52 bits used). The user must
// write it only while the pipeline is empty; the block does not enforce this.
module sphere_sphere_contact (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  ssc_pkg::in_word_t           in_word_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output ssc_pkg::out_word_t          out_word_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ssc_pkg::AddrW-1:0]   paddr,
  input  logic [ssc_pkg::DataW-1:0]   pwdata,
  output logic [ssc_pkg::DataW-1:0]   prdata,
  output logic                        pready
);

  logic                          en;
  logic [ssc_pkg::ThrW-1:0]      thr_q;
  logic                          f_v, s_v, d_v;
  ssc_pkg::ctx_t                 f_ctx, s_ctx, d_ctx;
  logic [ssc_pkg::SqW-1:0]       f_sq;
  logic [ssc_pkg::DistW-1:0]     s_dist, d_dist;
  logic [2:0][ssc_pkg::QuoW-1:0] d_quo;

  // Pipeline advances unless a finished word is stalled
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  // Threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ssc_pkg::ThresholdReset;
    end else if (psel && penable && pwrite && paddr[3] == ssc_pkg::RegThreshold) begin
      thr_q <= pwdata[ssc_pkg::ThrW-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[3] == ssc_pkg::RegThreshold) ?
                  {{(ssc_pkg::DataW-ssc_pkg::ThrW){1'b0}}, thr_q} : '0;

  ssc_front u_front (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_valid_i), .word_i(in_word_i),
    .thr_i(thr_q), .valid_o(f_v), .ctx_o(f_ctx), .sq_o(f_sq)
  );

  ssc_sqrt u_sqrt (
    .clk_i, .rst_ni, .en_i(en), .valid_i(f_v), .ctx_i(f_ctx), .sq_i(f_sq),
    .valid_o(s_v), .ctx_o(s_ctx), .dist_o(s_dist)
  );

  ssc_div u_div (
    .clk_i, .rst_ni, .en_i(en), .valid_i(s_v), .ctx_i(s_ctx), .dist_i(s_dist),
    .valid_o(d_v), .ctx_o(d_ctx), .dist_o(d_dist), .quo_o(d_quo)
  );

  ssc_back u_back (
    .clk_i, .rst_ni, .en_i(en), .valid_i(d_v), .ctx_i(d_ctx), .dist_i(d_dist),
    .quo_i(d_quo), .valid_o(out_valid_o), .word_o(out_word_o)
  );

endmodule

@@ rtl/ssc_checker.sv @@
// Port-level checks for sphere_sphere_contact, attached by bind.
// Depends on ssc_pkg.
module ssc_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input ssc_pkg::out_word_t out_word_o,
  input logic               pready
);

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o))
    else $error("stalled out word changed");

  // Stalled output blocks the input side
  a_stall_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input accepted during output stall");

  // Coincident fallback uses the fixed up normal
  a_coinc_normal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.coincident |->
      out_word_o.normal_x == 16'sd0 && out_word_o.normal_y == 16'sd16384 &&
      out_word_o.normal_z == 16'sd0)
    else $error("coincident word without up normal");

  // The x and z normal components stay within one
  a_normal_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_word_o.normal_x <= 16'sd16384 &&
      out_word_o.normal_x >= -16'sd16384 && out_word_o.normal_z <= 16'sd16384 &&
      out_word_o.normal_z >= -16'sd16384)
    else $error("normal out of range");

  a_pready: assert property (@(posedge clk_i) pready)
    else $error("pready low");

endmodule

bind sphere_sphere_contact ssc_checker u_ssc_checker (
  .clk_i, .rst_ni, .in_ready_o, .out_valid_o, .out_ready_i, .out_word_o, .pready
);
